### rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants of the code page transcoder
// Command codes, register indexes, table constants and the link that carries a
// search result along the row of encode cells.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int UPPER_ENTRIES_DEFAULT = 128;
  localparam int INDEX_W = 7;
  localparam int ENTRY_W = 16;

  localparam logic [7:0]         UPPER_BASE       = 8'h80;
  localparam logic [ENTRY_W-1:0] ENTRY_UNDEFINED  = 16'hFFFF;
  localparam logic [ENTRY_W-1:0] REPLACEMENT_CHAR = 16'hFFFD;

  typedef enum logic [1:0] {
    CMD_LOAD_DECODE = 2'd0,
    CMD_LOAD_ENCODE = 2'd1,
    CMD_DECODE      = 2'd2,
    CMD_ENCODE      = 2'd3
  } command_t;

  typedef enum logic {
    REG_DECODE_ENABLE = 1'b0,
    REG_ENCODE_ENABLE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] index;
  } match_link_t;

endpackage

### rtl/cpt_decoder.sv
// ----------------------------------------------------------------------------
// cpt_decoder: decode table and byte-to-code-point lookup
// Holds the decode table in a memory with a registered read and forms the
// decoded code point from the read data in the cycle after the byte is presented.
// ----------------------------------------------------------------------------
module cpt_decoder #(
  parameter int UPPER_ENTRIES = cpt_pkg::UPPER_ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [cpt_pkg::INDEX_W-1:0] wr_index,
  input  logic [cpt_pkg::ENTRY_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [7:0]                  rd_byte,
  input  logic                        enabled,
  output logic [cpt_pkg::ENTRY_W-1:0] decoded
);

  localparam int AW = (UPPER_ENTRIES > 1) ? $clog2(UPPER_ENTRIES) : 1;

  logic [cpt_pkg::ENTRY_W-1:0] mem [UPPER_ENTRIES];
  logic [cpt_pkg::ENTRY_W-1:0] rd_data;
  logic [7:0]                  byte_q;
  logic                        lookup_ok;
  logic                        wr_in_range;
  logic                        rd_in_range;

  assign wr_in_range = ({1'b0, wr_index} < 8'(UPPER_ENTRIES));
  assign rd_in_range = ({1'b0, rd_byte[cpt_pkg::INDEX_W-1:0]} < 8'(UPPER_ENTRIES));

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_index[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data   <= mem[rd_byte[AW-1:0]];
      byte_q    <= rd_byte;
      lookup_ok <= enabled && rd_in_range;
    end
  end

  // Lower half passes through; upper half takes the entry unless the table is
  // off, the byte lies past the table, or the entry marks an undefined byte.
  always_comb begin
    if (byte_q < cpt_pkg::UPPER_BASE) begin
      decoded = {8'h00, byte_q};
    end else if (!lookup_ok || rd_data == cpt_pkg::ENTRY_UNDEFINED) begin
      decoded = cpt_pkg::REPLACEMENT_CHAR;
    end else begin
      decoded = rd_data;
    end
  end

endmodule

### rtl/cpt_cell.sv
// ----------------------------------------------------------------------------
// cpt_cell: one encode table entry with its compare and link stage
// Stores one entry, compares it with the query and hands the search result
// toward the low-index end of the row, replacing it with its own index on a hit.
// ----------------------------------------------------------------------------
module cpt_cell #(
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [cpt_pkg::INDEX_W-1:0] wr_index,
  input  logic [cpt_pkg::ENTRY_W-1:0] wr_data,
  input  logic [cpt_pkg::ENTRY_W-1:0] query,
  input  cpt_pkg::match_link_t        link_in,
  output cpt_pkg::match_link_t        link_out
);

  localparam logic [cpt_pkg::INDEX_W-1:0] CELL_INDEX = cpt_pkg::INDEX_W'(INDEX);

  logic [cpt_pkg::ENTRY_W-1:0] entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (wr_en && wr_index == CELL_INDEX) begin
      entry <= wr_data;
    end
  end

  // A hit here beats anything from higher indexes.
  always_ff @(posedge clk) begin
    if (entry == query) begin
      link_out.hit   <= 1'b1;
      link_out.index <= CELL_INDEX;
    end else begin
      link_out <= link_in;
    end
  end

endmodule

### rtl/cpt_encoder.sv
// ----------------------------------------------------------------------------
// cpt_encoder: row of encode cells
// Chains one cell per table entry; the lowest matching index arrives at the
// head of the row after one pass through all cells.
// ----------------------------------------------------------------------------
module cpt_encoder #(
  parameter int UPPER_ENTRIES = cpt_pkg::UPPER_ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [cpt_pkg::INDEX_W-1:0] wr_index,
  input  logic [cpt_pkg::ENTRY_W-1:0] wr_data,
  input  logic [cpt_pkg::ENTRY_W-1:0] query,
  output cpt_pkg::match_link_t        head
);

  cpt_pkg::match_link_t links [UPPER_ENTRIES+1];

  assign links[UPPER_ENTRIES] = '0;
  assign head = links[0];

  for (genvar i = 0; i < UPPER_ENTRIES; i++) begin : g_cell
    cpt_cell #(
      .INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (wr_en),
      .wr_index(wr_index),
      .wr_data (wr_data),
      .query   (query),
      .link_in (links[i+1]),
      .link_out(links[i])
    );
  end

endmodule

### rtl/codepage_transcoder.sv
// ----------------------------------------------------------------------------
// codepage_transcoder: single-byte code page to and from Unicode
// Top level: command handshake, register port, sequencing of lookups and the
// result strobe.
// ----------------------------------------------------------------------------
// A command transfer is taken when start is high and busy is low. Load
// commands write one table entry and produce no result, so loads can stream
// back to back. A decode reads the decode table, a memory with a registered
// read, and then registers the result onto the result ports. For an encode,
// the encode table lives in a row of UPPER_ENTRIES cells, and the search
// result walks that row one cell per cycle toward index zero, so the lowest
// matching index is known only after a full pass. Each result is shown on
// the result ports for exactly one cycle with done high and must be captured
// in that cycle; busy stays high until the result is shown, so no result can
// be overwritten. Registers sit at byte address 0 (decode table enable) and
// 4 (encode table enable), bit 0, and should only be written while busy is
// low.
// ----------------------------------------------------------------------------
module codepage_transcoder #(
  parameter int UPPER_ENTRIES = cpt_pkg::UPPER_ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [6:0]  table_index,
  input  logic [15:0] load_value,
  input  logic [7:0]  byte_in,
  input  logic [31:0] char_in,
  // result channel
  output logic        done,
  output logic [15:0] decoded_char,
  output logic [7:0]  encoded_byte,
  output logic        status,
  output logic        is_encode,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(UPPER_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ENCODE
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            count;
  logic [31:0]                 query;
  logic                        decode_enable;
  logic                        encode_enable;
  logic                        accept;
  logic                        cfg_write;
  logic [15:0]                 dec_value;
  cpt_pkg::match_link_t        head;
  logic                        query_low;
  logic                        enc_found;
  logic [7:0]                  enc_byte;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------- registers
  // The register index is taken from the word address bit; both registers are
  // a single flag in bit 0.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_enable <= 1'b0;
      encode_enable <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == cpt_pkg::REG_ENCODE_ENABLE) begin
        encode_enable <= pwdata[0];
      end else begin
        decode_enable <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == cpt_pkg::REG_ENCODE_ENABLE) ? {31'b0, encode_enable}
                                                           : {31'b0, decode_enable};

  // ---------------------------------------------------------------- tables
  cpt_decoder #(
    .UPPER_ENTRIES(UPPER_ENTRIES)
  ) u_decoder (
    .clk     (clk),
    .wr_en   (accept && command == cpt_pkg::CMD_LOAD_DECODE),
    .wr_index(table_index),
    .wr_data (load_value),
    .rd_en   (accept && command == cpt_pkg::CMD_DECODE),
    .rd_byte (byte_in),
    .enabled (decode_enable),
    .decoded (dec_value)
  );

  // The encode row compares against the captured query, which holds steady
  // for the whole search because busy blocks new commands.
  cpt_encoder #(
    .UPPER_ENTRIES(UPPER_ENTRIES)
  ) u_encoder (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && command == cpt_pkg::CMD_LOAD_ENCODE),
    .wr_index(table_index),
    .wr_data (load_value),
    .query   (query[15:0]),
    .head    (head)
  );

  // ---------------------------------------------------------------- encode result
  // ASCII passes through. Anything else needs the table on and a code point
  // that fits an entry; table entries of zero never match because such a
  // query is always at least 0x80.
  assign query_low = (query[31:7] == '0);
  assign enc_found = encode_enable && (query[31:16] == '0) && head.hit;

  always_comb begin
    if (query_low) begin
      enc_byte = query[7:0];
    end else if (enc_found) begin
      enc_byte = cpt_pkg::UPPER_BASE | 8'(head.index);
    end else begin
      enc_byte = 8'h00;
    end
  end

  // ---------------------------------------------------------------- sequencer
  // The encode search counts until the result has reached the head of the row,
  // then registers it onto the result ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && command == cpt_pkg::CMD_DECODE) begin
            state <= ST_DECODE;
          end else if (accept && command == cpt_pkg::CMD_ENCODE) begin
            state <= ST_ENCODE;
            query <= char_in;
            count <= '0;
          end
        end
        ST_DECODE: begin
          done         <= 1'b1;
          decoded_char <= dec_value;
          encoded_byte <= 8'h00;
          status       <= 1'b0;
          is_encode    <= 1'b0;
          state        <= ST_IDLE;
        end
        ST_ENCODE: begin
          if (count == CNT_W'(UPPER_ENTRIES)) begin
            done         <= 1'b1;
            decoded_char <= 16'h0000;
            encoded_byte <= enc_byte;
            status       <= !query_low && !enc_found;
            is_encode    <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            count <= count + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/cpt_checker.sv
// ----------------------------------------------------------------------------
// cpt_checker: port-level checks of the code page transcoder
// Watches the command and result ports and checks result shape and timing.
// ----------------------------------------------------------------------------
module cpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  command,
  input logic        done,
  input logic [15:0] decoded_char,
  input logic [7:0]  encoded_byte,
  input logic        status,
  input logic        is_encode
);

  // A result transfer frees the block for the next command in the same cycle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy high while a result is shown");

  // Every decode command transfer is followed by its decode result.
  a_decode_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == cpt_pkg::CMD_DECODE) |-> ##2 (done && !is_encode))
    else $error("decode result missing or late");

  a_decode_shape: assert property (@(posedge clk) disable iff (rst)
    (done && !is_encode) |-> (status == 1'b0 && encoded_byte == 8'h00))
    else $error("decode result carries encode fields");

  a_encode_shape: assert property (@(posedge clk) disable iff (rst)
    (done && is_encode) |-> (decoded_char == 16'h0000 &&
                             (status == 1'b0 || encoded_byte == 8'h00)))
    else $error("encode result fields inconsistent");

endmodule

bind codepage_transcoder cpt_checker u_cpt_checker (.*);

### tb/tb_codepage_transcoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_codepage_transcoder: self-checking testbench for the code page transcoder
// A queue of commands is filled up front and fed to the block by a clocked
// driver with bursty timing. A clocked monitor keeps its own copy of both
// tables and both enable registers, predicts every decode and encode result
// at the transfer that starts it, and compares each strobed result with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_codepage_transcoder;

  localparam int TB_ENTRIES     = cpt_pkg::UPPER_ENTRIES_DEFAULT;
  localparam int ENCODE_LATENCY = TB_ENTRIES + 2;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int POOL_SIZE      = 12;
  localparam int PHASE_ITEMS    = 145;
  localparam int NUM_PHASES     = 5;

  // One entry of the stimulus queue: a command, a register write, or a pause
  // that makes the sender wait until every outstanding result has come back.
  typedef enum logic [1:0] {
    ITEM_CMD,
    ITEM_REG,
    ITEM_PAUSE
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    cpt_pkg::command_t   cmd;
    logic [6:0]          idx;
    logic [15:0]         entry;
    logic [7:0]          byte_val;
    logic [31:0]         char_val;
    cpt_pkg::reg_index_t reg_sel;
    logic [31:0]         reg_data;
  } stim_item_t;

  typedef struct packed {
    logic [15:0] decoded;
    logic [7:0]  encoded;
    logic        status;
    logic        is_enc;
  } xcode_result_t;

  typedef enum logic [2:0] {
    DRV_FETCH,
    DRV_CMD,
    DRV_DRAIN,
    DRV_SETTLE,
    DRV_SETUP,
    DRV_ACCESS
  } drv_state_t;

  // Every input of the block starts at a known value.
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic        busy;
  logic [1:0]  command     = '0;
  logic [6:0]  table_index = '0;
  logic [15:0] load_value  = '0;
  logic [7:0]  byte_in     = '0;
  logic [31:0] char_in     = '0;
  logic        done;
  logic [15:0] decoded_char;
  logic [7:0]  encoded_byte;
  logic        status;
  logic        is_encode;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  codepage_transcoder #(
    .UPPER_ENTRIES(TB_ENTRIES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .table_index  (table_index),
    .load_value   (load_value),
    .byte_in      (byte_in),
    .char_in      (char_in),
    .done         (done),
    .decoded_char (decoded_char),
    .encoded_byte (encoded_byte),
    .status       (status),
    .is_encode    (is_encode),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Reset starts high and is released on a falling edge.
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the tables and enables as the block should hold them.
  // --------------------------------------------------------------------------
  logic [15:0]   model_dec_tbl [TB_ENTRIES];
  logic [15:0]   model_enc_tbl [TB_ENTRIES];
  logic          model_dec_on;
  logic          model_enc_on;
  xcode_result_t awaited_results [$];
  int unsigned   mismatch_count = 0;

  // Handshake flags written by the monitor at the rising edge and read by the
  // driver at the next falling edge.
  bit cmd_taken = 1'b0;
  bit reg_taken = 1'b0;

  // Applies one accepted command to the predictor state. Returns 1 when the
  // command produces a result, which is then placed in res.
  function automatic bit transcode_predict(input stim_item_t it, output xcode_result_t res);
    int hit;
    int slot;
    int i;
    res = '0;
    case (it.cmd)
      cpt_pkg::CMD_LOAD_DECODE: begin
        if (int'(it.idx) < TB_ENTRIES) model_dec_tbl[it.idx] = it.entry;
        return 1'b0;
      end
      cpt_pkg::CMD_LOAD_ENCODE: begin
        if (int'(it.idx) < TB_ENTRIES) model_enc_tbl[it.idx] = it.entry;
        return 1'b0;
      end
      cpt_pkg::CMD_DECODE: begin
        slot = int'(it.byte_val) - int'(cpt_pkg::UPPER_BASE);
        if (it.byte_val < cpt_pkg::UPPER_BASE) begin
          // The lower half of the byte range is plain ASCII.
          res.decoded = {8'h00, it.byte_val};
        end else if (!model_dec_on || slot >= TB_ENTRIES) begin
          res.decoded = cpt_pkg::REPLACEMENT_CHAR;
        end else if (model_dec_tbl[slot] == cpt_pkg::ENTRY_UNDEFINED) begin
          res.decoded = cpt_pkg::REPLACEMENT_CHAR;
        end else begin
          res.decoded = model_dec_tbl[slot];
        end
        return 1'b1;
      end
      default: begin
        res.is_enc = 1'b1;
        if (it.char_val < 32'(cpt_pkg::UPPER_BASE)) begin
          res.encoded = it.char_val[7:0];
        end else begin
          // Scan downward so that the lowest matching index is the one kept.
          // A code point above 16 bits can never match.
          hit = -1;
          if (model_enc_on && it.char_val[31:16] == 16'h0000) begin
            for (i = TB_ENTRIES - 1; i >= 0; i--) begin
              if (model_enc_tbl[i] == it.char_val[15:0]) hit = i;
            end
          end
          if (hit < 0) begin
            res.status = 1'b1;
          end else begin
            res.encoded = cpt_pkg::UPPER_BASE + 8'(hit);
          end
        end
        return 1'b1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: checks strobed results, then records new command and register
  // transfers. All sampling happens at the rising edge, so the values seen
  // are the ones the block itself sees at that edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    xcode_result_t want;
    xcode_result_t got;
    stim_item_t    seen;
    int            i;
    cmd_taken = 1'b0;
    reg_taken = 1'b0;
    if (rst) begin
      for (i = 0; i < TB_ENTRIES; i++) begin
        model_dec_tbl[i] = '0;
        model_enc_tbl[i] = '0;
      end
      model_dec_on = 1'b0;
      model_enc_on = 1'b0;
    end else begin
      // A result belongs to a command taken earlier, so it is checked before
      // a command taken at this same edge adds its own prediction.
      if (done) begin
        got = {decoded_char, encoded_byte, status, is_encode};
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: result with none expected: char %h byte %h status %b enc %b",
                     got.decoded, got.encoded, got.status, got.is_enc);
        end else begin
          want = awaited_results.pop_front();
          if (got.decoded !== want.decoded || got.encoded !== want.encoded ||
              got.status !== want.status || got.is_enc !== want.is_enc) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected char %h byte %h status %b enc %b, got %h %h %b %b",
                       want.decoded, want.encoded, want.status, want.is_enc,
                       got.decoded, got.encoded, got.status, got.is_enc);
          end
        end
      end
      if (start && !busy) begin
        cmd_taken     = 1'b1;
        seen          = '0;
        seen.kind     = ITEM_CMD;
        seen.cmd      = cpt_pkg::command_t'(command);
        seen.idx      = table_index;
        seen.entry    = load_value;
        seen.byte_val = byte_in;
        seen.char_val = char_in;
        if (transcode_predict(seen, want)) awaited_results.push_back(want);
      end
      if (psel && penable && pwrite && pready) begin
        reg_taken = 1'b1;
        case (cpt_pkg::reg_index_t'(paddr[2]))
          cpt_pkg::REG_DECODE_ENABLE: model_dec_on = pwdata[0];
          cpt_pkg::REG_ENCODE_ENABLE: model_enc_on = pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: takes entries from the queue at the falling edge. Commands go out
  // in bursts of random length separated by random gaps, so start drops at
  // every point of a long encode search as well as between short loads.
  // Register writes and pauses first wait for the block to go quiet.
  // --------------------------------------------------------------------------
  stim_item_t queued_commands [$];
  stim_item_t held_item;
  drv_state_t drv_state   = DRV_FETCH;
  int         burst_left  = 0;
  int         gap_left    = 0;
  int         settle_left = 0;

  always @(negedge clk) begin
    stim_item_t nxt;
    logic       drive_start;
    int         r;
    // start is worked out here and assigned once, so a command that follows
    // straight on keeps start high without a glitch in the same time step.
    drive_start = start;
    if (!rst) begin
      if (drv_state == DRV_CMD && cmd_taken) begin
        drive_start = 1'b0;
        drv_state   = DRV_FETCH;
      end
      case (drv_state)
        DRV_FETCH: begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (queued_commands.size() > 0) begin
            nxt = queued_commands.pop_front();
            if (nxt.kind == ITEM_CMD) begin
              command     <= nxt.cmd;
              table_index <= nxt.idx;
              load_value  <= nxt.entry;
              byte_in     <= nxt.byte_val;
              char_in     <= nxt.char_val;
              drive_start = 1'b1;
              drv_state   = DRV_CMD;
              if (burst_left > 0) begin
                burst_left--;
              end else begin
                // End of a burst: choose the next burst and the gap before it.
                // Most gaps are short; a few outlast a whole encode search.
                burst_left = $urandom_range(0, 24);
                r = $urandom_range(0, 9);
                if (r < 4) gap_left = 0;
                else if (r < 7) gap_left = $urandom_range(1, 4);
                else if (r < 9) gap_left = $urandom_range(5, 30);
                else gap_left = $urandom_range(31, ENCODE_LATENCY + 20);
              end
            end else begin
              held_item = nxt;
              drv_state = DRV_DRAIN;
            end
          end
        end
        DRV_DRAIN: begin
          if (awaited_results.size() == 0 && !busy) begin
            // Loads leave no result behind, so a settle wait follows to let the last one
            // land before the registers change.
            settle_left = SETTLE_CYCLES;
            drv_state   = DRV_SETTLE;
          end
        end
        DRV_SETTLE: begin
          if (settle_left > 0) begin
            settle_left--;
          end else if (held_item.kind == ITEM_REG) begin
            psel      <= 1'b1;
            penable   <= 1'b0;
            pwrite    <= 1'b1;
            paddr     <= {held_item.reg_sel, 2'b00};
            pwdata    <= held_item.reg_data;
            drv_state = DRV_SETUP;
          end else begin
            drv_state = DRV_FETCH;
          end
        end
        DRV_SETUP: begin
          penable   <= 1'b1;
          drv_state = DRV_ACCESS;
        end
        DRV_ACCESS: begin
          if (reg_taken) begin
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            drv_state = DRV_FETCH;
          end
        end
        default: ;
      endcase
    end
    start <= drive_start;
  end

  // --------------------------------------------------------------------------
  // Stimulus. The generator keeps track of which decode entries it has
  // loaded, and upper bytes are only decoded once their entry holds a value.
  // Encode loads mostly use a small pool of code points so that encodes hit,
  // and duplicate entries turn up often.
  // --------------------------------------------------------------------------
  bit          dec_written [TB_ENTRIES];
  int          written_slots [$];
  logic [15:0] char_pool [POOL_SIZE];

  function automatic stim_item_t make_cmd(cpt_pkg::command_t c);
    stim_item_t it;
    // Fields a command does not use still carry random values.
    it          = '0;
    it.kind     = ITEM_CMD;
    it.cmd      = c;
    it.idx      = 7'($urandom);
    it.entry    = 16'($urandom);
    it.byte_val = 8'($urandom);
    it.char_val = $urandom;
    return it;
  endfunction

  task automatic add_load(cpt_pkg::command_t c, int slot, logic [15:0] value);
    stim_item_t it;
    it       = make_cmd(c);
    it.idx   = 7'(slot);
    it.entry = value;
    queued_commands.push_back(it);
    if (c == cpt_pkg::CMD_LOAD_DECODE && !dec_written[slot]) begin
      dec_written[slot] = 1'b1;
      written_slots.push_back(slot);
    end
  endtask

  task automatic add_decode(logic [7:0] b);
    stim_item_t it;
    it          = make_cmd(cpt_pkg::CMD_DECODE);
    it.byte_val = b;
    queued_commands.push_back(it);
  endtask

  task automatic add_encode(logic [31:0] ch);
    stim_item_t it;
    it          = make_cmd(cpt_pkg::CMD_ENCODE);
    it.char_val = ch;
    queued_commands.push_back(it);
  endtask

  task automatic add_reg_write(cpt_pkg::reg_index_t sel, logic value);
    stim_item_t it;
    it          = '0;
    it.kind     = ITEM_REG;
    it.reg_sel  = sel;
    it.reg_data = {31'($urandom), value};
    queued_commands.push_back(it);
  endtask

  task automatic add_pause();
    stim_item_t it;
    it      = '0;
    it.kind = ITEM_PAUSE;
    queued_commands.push_back(it);
  endtask

  initial begin
    logic        phase_dec [NUM_PHASES];
    logic        phase_enc [NUM_PHASES];
    logic [15:0] e;
    logic [31:0] ch;
    int          ph;
    int          n;
    int          pick;
    int          r;
    int          pause_at;

    phase_dec = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_enc = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    char_pool[0] = 16'h0080;
    char_pool[1] = cpt_pkg::ENTRY_UNDEFINED;
    char_pool[2] = cpt_pkg::REPLACEMENT_CHAR;
    for (n = 3; n < POOL_SIZE; n++) char_pool[n] = 16'($urandom_range(16'h0080, 16'hFFFF));

    // Directed part, first with both tables disabled as they come out of reset.
    add_encode(32'h0000_0041);
    add_encode(32'h0000_0080);            // disabled table: unrepresentable
    add_encode(32'h0000_0000);
    add_decode(8'h00);
    add_decode(8'h7F);
    add_load(cpt_pkg::CMD_LOAD_DECODE, 0, 16'h20AC);
    add_load(cpt_pkg::CMD_LOAD_DECODE, TB_ENTRIES - 1, cpt_pkg::ENTRY_UNDEFINED);
    add_decode(cpt_pkg::UPPER_BASE);      // disabled table: replacement char
    add_reg_write(cpt_pkg::REG_DECODE_ENABLE, 1'b1);
    add_reg_write(cpt_pkg::REG_ENCODE_ENABLE, 1'b1);
    add_decode(cpt_pkg::UPPER_BASE);
    add_decode(8'hFF);                    // undefined entry: replacement char
    add_load(cpt_pkg::CMD_LOAD_DECODE, TB_ENTRIES - 1, 16'hFFFE);
    add_decode(8'hFF);
    add_load(cpt_pkg::CMD_LOAD_DECODE, 1, 16'h0000);
    add_decode(8'h81);
    // Two entries with the same code point: the lower index must win.
    add_load(cpt_pkg::CMD_LOAD_ENCODE, 5, 16'h00E9);
    add_load(cpt_pkg::CMD_LOAD_ENCODE, 3, 16'h00E9);
    add_encode(32'h0000_00E9);
    add_load(cpt_pkg::CMD_LOAD_ENCODE, TB_ENTRIES - 1, 16'hFFFF);
    add_encode(32'h0000_FFFF);
    add_encode(32'h0001_00E9);            // above 16 bits, low half matches
    add_encode(32'hFFFF_FFFF);
    add_encode(32'h0000_0080);            // zero entries never match
    add_load(cpt_pkg::CMD_LOAD_ENCODE, 0, 16'h0080);
    add_encode(32'h0000_0080);

    // Random part: several phases, each under its own register setting, with
    // one pause somewhere inside every phase.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      add_reg_write(cpt_pkg::REG_DECODE_ENABLE, phase_dec[ph]);
      add_reg_write(cpt_pkg::REG_ENCODE_ENABLE, phase_enc[ph]);
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at) add_pause();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          r = $urandom_range(0, 9);
          if (r < 2) e = cpt_pkg::ENTRY_UNDEFINED;
          else if (r == 2) e = cpt_pkg::REPLACEMENT_CHAR;
          else e = 16'($urandom);
          add_load(cpt_pkg::CMD_LOAD_DECODE, $urandom_range(0, TB_ENTRIES - 1), e);
        end else if (pick < 40) begin
          r = $urandom_range(0, 9);
          if (r < 7) e = char_pool[$urandom_range(0, POOL_SIZE - 1)];
          else if (r < 9) e = 16'($urandom);
          else e = 16'h0000;
          add_load(cpt_pkg::CMD_LOAD_ENCODE, $urandom_range(0, TB_ENTRIES - 1), e);
        end else if (pick < 70) begin
          if ($urandom_range(0, 9) < 3)
            add_decode(8'($urandom_range(0, 127)));
          else
            add_decode(cpt_pkg::UPPER_BASE +
                       8'(written_slots[$urandom_range(0, written_slots.size() - 1)]));
        end else begin
          r = $urandom_range(0, 19);
          if (r < 10) ch = {16'h0000, char_pool[$urandom_range(0, POOL_SIZE - 1)]};
          else if (r < 12) ch = 32'($urandom_range(0, 127));
          else if (r < 15) ch = $urandom;
          else if (r < 18) ch = {16'h0000, 16'($urandom)};
          else ch = {16'($urandom_range(1, 16'hFFFF)),
                     char_pool[$urandom_range(0, POOL_SIZE - 1)]};
          add_encode(ch);
        end
      end
    end

    // Wait for the queue to drain and the last transfer to be taken, then for
    // every predicted result, then for one more encode search in case the
    // block sends anything it should not.
    while (queued_commands.size() != 0 || drv_state != DRV_FETCH || start) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (ENCODE_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

### files.f
rtl/cpt_pkg.sv
rtl/cpt_decoder.sv
rtl/cpt_cell.sv
rtl/cpt_encoder.sv
rtl/codepage_transcoder.sv
rtl/cpt_checker.sv
tb/tb_codepage_transcoder.sv
